// File: sv/rse_pkg.sv
// Package for the readability score engine.
// Holds the item and score types, character codes and score term codes.
// No dependencies.
`timescale 1ns / 1ps

package rse_pkg;

  localparam int OUT_W = 48;
  localparam int NUM_TERMS = 6;

  typedef struct packed {
    logic [7:0] char_code;
    logic       word_last;
    logic       sentence_end;
    logic       finish;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] reading_ease;
    logic signed [OUT_W-1:0] grade_level;
    logic signed [OUT_W-1:0] fog_index;
    logic                    empty_text;
  } score_t;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CASE_OFS = 8'h20;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_O = 8'h6F;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_Y = 8'h79;

  localparam logic [7:0] CPLX_LEN_RESET = 8'd8;

  localparam logic [2:0] T_RE_SENT  = 3'd0;
  localparam logic [2:0] T_RE_SYL   = 3'd1;
  localparam logic [2:0] T_GL_SENT  = 3'd2;
  localparam logic [2:0] T_GL_SYL   = 3'd3;
  localparam logic [2:0] T_FOG_SENT = 3'd4;
  localparam logic [2:0] T_FOG_CPLX = 3'd5;

  function automatic logic is_vowel(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CH_CASE_OFS : c;
    return (l == CH_A) || (l == CH_E) || (l == CH_I) || (l == CH_O) ||
           (l == CH_U) || (l == CH_Y);
  endfunction

endpackage

// File: sv/rse_fifo.sv
// Small register queue between the counting front end and the score back end.
// Depends on nothing.
`timescale 1ns / 1ps

module rse_fifo #(
  parameter int WIDTH = 104,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/rse_front.sv
// Front end of the readability score engine: classifies characters and keeps
// the word, syllable, sentence and complex word counts. Uses rse_pkg.
`timescale 1ns / 1ps

module rse_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  logic                  take,
  input  rse_pkg::item_t        item,
  output logic                  snap_push,
  output logic [COUNT_BITS-1:0] snap_words,
  output logic [COUNT_BITS-1:0] snap_sents,
  output logic [31:0]           snap_syls,
  output logic [COUNT_BITS-1:0] snap_cplx
);

  import rse_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [7:0] cplx_len;
  logic       prev_vowel;
  logic [7:0] word_syl;
  logic [7:0] word_len;
  logic [31:0] total_syl;
  logic [COUNT_BITS-1:0] word_cnt;
  logic [COUNT_BITS-1:0] sent_cnt;
  logic [COUNT_BITS-1:0] cplx_cnt;

  logic       prev_vowel_next;
  logic [7:0] word_syl_next;
  logic [7:0] word_len_next;
  logic [31:0] total_syl_next;
  logic [COUNT_BITS-1:0] word_cnt_next;
  logic [COUNT_BITS-1:0] sent_cnt_next;
  logic [COUNT_BITS-1:0] cplx_cnt_next;

  logic       vowel;
  logic [7:0] len_inc;
  logic [7:0] syl_inc;
  logic [7:0] syl_adj;
  logic [32:0] syl_sum;

  assign snap_push  = take && item.finish;
  assign snap_words = word_cnt;
  assign snap_sents = sent_cnt;
  assign snap_syls  = total_syl;
  assign snap_cplx  = cplx_cnt;

  always_comb begin
    vowel   = is_vowel(item.char_code);
    len_inc = (word_len == 8'hFF) ? word_len : word_len + 8'd1;
    syl_inc = (vowel && !prev_vowel && word_syl != 8'hFF) ? word_syl + 8'd1 : word_syl;
    syl_adj = syl_inc;
    if (len_inc > 8'd2 && item.char_code == CH_E && syl_inc > 8'd1) begin
      syl_adj = syl_inc - 8'd1;
    end
    if (syl_adj == 8'd0) begin
      syl_adj = 8'd1;
    end
    syl_sum = {1'b0, total_syl} + {25'd0, syl_adj};

    prev_vowel_next = prev_vowel;
    word_syl_next   = word_syl;
    word_len_next   = word_len;
    total_syl_next  = total_syl;
    word_cnt_next   = word_cnt;
    sent_cnt_next   = sent_cnt;
    cplx_cnt_next   = cplx_cnt;

    if (take) begin
      if (item.finish) begin
        prev_vowel_next = 1'b0;
        word_syl_next   = '0;
        word_len_next   = '0;
        total_syl_next  = '0;
        word_cnt_next   = '0;
        sent_cnt_next   = '0;
        cplx_cnt_next   = '0;
      end else begin
        prev_vowel_next = vowel;
        word_syl_next   = syl_inc;
        word_len_next   = len_inc;
        if (item.word_last) begin
          total_syl_next  = syl_sum[32] ? 32'hFFFF_FFFF : syl_sum[31:0];
          word_cnt_next   = (word_cnt == CNT_MAX) ? word_cnt : word_cnt + 1'b1;
          if (len_inc >= cplx_len && cplx_cnt != CNT_MAX) begin
            cplx_cnt_next = cplx_cnt + 1'b1;
          end
          prev_vowel_next = 1'b0;
          word_syl_next   = '0;
          word_len_next   = '0;
        end
        if (item.sentence_end && sent_cnt != CNT_MAX) begin
          sent_cnt_next = sent_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cplx_len   <= CPLX_LEN_RESET;
      prev_vowel <= 1'b0;
      word_syl   <= '0;
      word_len   <= '0;
      total_syl  <= '0;
      word_cnt   <= '0;
      sent_cnt   <= '0;
      cplx_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        cplx_len <= cfg_data;
      end
      prev_vowel <= prev_vowel_next;
      word_syl   <= word_syl_next;
      word_len   <= word_len_next;
      total_syl  <= total_syl_next;
      word_cnt   <= word_cnt_next;
      sent_cnt   <= sent_cnt_next;
      cplx_cnt   <= cplx_cnt_next;
    end
  end

endmodule

// File: sv/rse_div.sv
// Restoring divider for the score terms, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module rse_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? DEN_W'(rem_sh - {1'b0, dvs}) : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/rse_back.sv
// Back end of the readability score engine: turns one set of counts into the
// three scores with a shared divider and holds the score for the output side.
// Uses rse_pkg and rse_div.
`timescale 1ns / 1ps

module rse_back #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  snap_valid,
  output logic                  snap_pop,
  input  logic [COUNT_BITS-1:0] snap_words,
  input  logic [COUNT_BITS-1:0] snap_sents,
  input  logic [31:0]           snap_syls,
  input  logic [COUNT_BITS-1:0] snap_cplx,
  output rse_pkg::score_t       score,
  output logic                  empty,
  input  logic                  pop
);

  import rse_pkg::*;

  localparam int PROD_W = 42;
  localparam int DEN_W  = COUNT_BITS + 11;
  localparam int NUM_W  = 44 + FRAC_BITS;
  localparam int SUM_W  = NUM_W + 2;
  localparam longint C_RE = (longint'(413670) * (longint'(1) << FRAC_BITS) + 1000) / 2000;
  localparam longint C_GL = (longint'(3118) * (longint'(1) << FRAC_BITS) + 100) / 200;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((longint'(1) << (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_SUM   = 7'b0010000,
    ST_SAT   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [COUNT_BITS-1:0] w_cnt;
  logic [COUNT_BITS-1:0] s_cnt;
  logic [31:0]           y_cnt;
  logic [COUNT_BITS-1:0] c_cnt;
  logic                  no_text;
  logic [2:0]            term;
  logic [PROD_W-1:0]     prod;
  logic [DEN_W-1:0]      den;
  logic [NUM_W-1:0]      quo_r [NUM_TERMS];
  logic signed [SUM_W-1:0] re_sum;
  logic signed [SUM_W-1:0] gl_sum;
  logic signed [SUM_W-1:0] fog_sum;
  score_t                pend;
  logic                  rvalid;

  logic [9:0]            k_sel;
  logic [31:0]           x_sel;
  logic [10:0]           dm_sel;
  logic [COUNT_BITS-1:0] dx_sel;
  logic [NUM_W-1:0]      div_num;
  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;
  logic                  load_out;

  always_comb begin
    case (term)
      T_RE_SENT: begin
        k_sel = 10'd1015; x_sel = 32'(w_cnt); dm_sel = 11'd2000; dx_sel = s_cnt;
      end
      T_RE_SYL: begin
        k_sel = 10'd846;  x_sel = y_cnt;       dm_sel = 11'd20;   dx_sel = w_cnt;
      end
      T_GL_SENT: begin
        k_sel = 10'd39;   x_sel = 32'(w_cnt); dm_sel = 11'd200;  dx_sel = s_cnt;
      end
      T_GL_SYL: begin
        k_sel = 10'd118;  x_sel = y_cnt;       dm_sel = 11'd20;   dx_sel = w_cnt;
      end
      T_FOG_SENT: begin
        k_sel = 10'd4;    x_sel = 32'(w_cnt); dm_sel = 11'd20;   dx_sel = s_cnt;
      end
      T_FOG_CPLX: begin
        k_sel = 10'd40;   x_sel = 32'(c_cnt); dm_sel = 11'd2;    dx_sel = w_cnt;
      end
      default: begin
        k_sel = '0;       x_sel = '0;          dm_sel = 11'd1;    dx_sel = '1;
      end
    endcase
  end

  assign div_num   = (NUM_W'(prod) << (FRAC_BITS + 1)) + NUM_W'(den >> 1);
  assign div_start = (state == ST_LOAD);
  assign snap_pop  = (state == ST_IDLE) && snap_valid;
  assign load_out  = (state == ST_OUT) && (!rvalid || pop);
  assign empty     = !rvalid;

  rse_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (snap_valid) begin
          state_next = (snap_words == '0 || snap_sents == '0) ? ST_SAT : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = (term == T_FOG_CPLX) ? ST_SUM : ST_MUL;
        end
      end
      ST_SUM:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (snap_pop) begin
      w_cnt   <= snap_words;
      s_cnt   <= snap_sents;
      y_cnt   <= snap_syls;
      c_cnt   <= snap_cplx;
      no_text <= (snap_words == '0 || snap_sents == '0);
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(k_sel) * PROD_W'(x_sel);
      den  <= DEN_W'(dm_sel) * DEN_W'(dx_sel);
    end
    if (state == ST_DIV && div_done) begin
      quo_r[term] <= div_quo;
    end
    if (state == ST_SUM) begin
      re_sum  <= SUM_W'(C_RE) - $signed({2'b00, quo_r[T_RE_SENT]})
                 - $signed({2'b00, quo_r[T_RE_SYL]});
      gl_sum  <= $signed({2'b00, quo_r[T_GL_SENT]}) + $signed({2'b00, quo_r[T_GL_SYL]})
                 - SUM_W'(C_GL);
      fog_sum <= $signed({2'b00, quo_r[T_FOG_SENT]}) + $signed({2'b00, quo_r[T_FOG_CPLX]});
    end
    if (state == ST_SAT) begin
      if (no_text) begin
        pend <= '{reading_ease: '0, grade_level: '0, fog_index: '0, empty_text: 1'b1};
      end else begin
        pend <= '{reading_ease: sat_out(re_sum), grade_level: sat_out(gl_sum),
                  fog_index: sat_out(fog_sum), empty_text: 1'b0};
      end
    end
    if (load_out) begin
      score <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      term   <= '0;
      rvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        term <= T_RE_SENT;
      end else if (state == ST_DIV && div_done) begin
        term <= term + 3'd1;
      end
      if (load_out) begin
        rvalid <= 1'b1;
      end else if (pop) begin
        rvalid <= 1'b0;
      end
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("Divider finished outside the divide state.");

  a_score_held: assert property (@(posedge clk) disable iff (rst)
    rvalid && !pop |=> rvalid && $stable(score))
    else $error("Waiting score was lost or changed.");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rvalid && score.empty_text |-> score.reading_ease == '0 &&
    score.grade_level == '0 && score.fog_index == '0)
    else $error("Empty text score carries nonzero values.");

endmodule

// File: sv/readability_score_engine_top.sv
// Top level of the readability score engine: front end counters, a request
// queue of finished counts, and the score back end. Uses rse_pkg, rse_front, rse_fifo, rse_back.
//
//   channel   ports                        moves
//   input     push, full, item             one character or finish request
//   result    empty, pop, score            three scores and empty flag
//   config    cfg_we, cfg_data             complex word length
//
// A character request is taken every cycle while the queue is not full. A
// finish request is taken and queued; the back end works on one queued request
// at a time with the shared one-bit-per-cycle divider.
// Up to two finish requests wait in the queue; full rises when it is full.
// Reset is synchronous; it clears all counts and sets the length to 8.
`timescale 1ns / 1ps

module readability_score_engine_top #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  input  logic            push,
  output logic            full,
  input  rse_pkg::item_t  item,
  output logic            empty,
  input  logic            pop,
  output rse_pkg::score_t score
);

  import rse_pkg::*;

  localparam int SNAP_W = 3 * COUNT_BITS + 32;
  localparam int Q_DEPTH = 2;

  logic                  snap_push;
  logic [COUNT_BITS-1:0] f_words;
  logic [COUNT_BITS-1:0] f_sents;
  logic [31:0]           f_syls;
  logic [COUNT_BITS-1:0] f_cplx;
  logic [SNAP_W-1:0]     q_rdata;
  logic                  q_empty;
  logic                  q_pop;

  rse_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .take       (push && !full),
    .item       (item),
    .snap_push  (snap_push),
    .snap_words (f_words),
    .snap_sents (f_sents),
    .snap_syls  (f_syls),
    .snap_cplx  (f_cplx)
  );

  rse_fifo #(
    .WIDTH (SNAP_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (snap_push),
    .wdata ({f_words, f_sents, f_syls, f_cplx}),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rse_back #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (!q_empty),
    .snap_pop   (q_pop),
    .snap_words (q_rdata[SNAP_W-1 -: COUNT_BITS]),
    .snap_sents (q_rdata[2*COUNT_BITS+31 -: COUNT_BITS]),
    .snap_syls  (q_rdata[COUNT_BITS+31 -: 32]),
    .snap_cplx  (q_rdata[COUNT_BITS-1:0]),
    .score      (score),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
